FILE: design/pcd_pkg.sv
// ---------------------------------------------------------------------------
// pcd_pkg: shared types and constants
// Widths, register indexes, reset values and the sequencer states of the
// PWM CO2 ppm decoder.
// ---------------------------------------------------------------------------
package pcd_pkg;

  localparam int CNT_W    = 21;
  localparam int FS_W     = 14;
  localparam int OFS_W    = 16;
  localparam int PWIN_W   = 21;
  localparam int PPM_W    = 14;
  localparam int PERIOD_W = 21;
  localparam int PROD_W   = FS_W + CNT_W;
  localparam int DCNT_W   = $clog2(PROD_W);
  localparam int CMP_W    = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
  localparam int CFG_W    = 21;
  localparam int IDX_W    = 3;

  localparam logic [IDX_W-1:0] REG_FULL_SCALE = 3'd0;
  localparam logic [IDX_W-1:0] REG_HIGH_OFS   = 3'd1;
  localparam logic [IDX_W-1:0] REG_PERIOD_OFS = 3'd2;
  localparam logic [IDX_W-1:0] REG_PERIOD_MIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_PERIOD_MAX = 3'd4;

  localparam logic [FS_W-1:0]   RST_FULL_SCALE = 14'd5000;
  localparam logic [OFS_W-1:0]  RST_HIGH_OFS   = 16'd2000;
  localparam logic [OFS_W-1:0]  RST_PERIOD_OFS = 16'd4000;
  localparam logic [PWIN_W-1:0] RST_PERIOD_MIN = 21'd900000;
  localparam logic [PWIN_W-1:0] RST_PERIOD_MAX = 21'd1100000;

  localparam logic [PPM_W-1:0]    PPM_MAX    = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PREP,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             done;
    logic [PPM_W-1:0] quot;
  } div_stat_t;

endpackage

FILE: design/pcd_div.sv
// ---------------------------------------------------------------------------
// pcd_div: bit-serial restoring divider
// One quotient bit per cycle over the full dividend width; the quotient
// is saturated to the ppm range when done is reported.
// ---------------------------------------------------------------------------
module pcd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pcd_pkg::PROD_W-1:0] dividend_i,
  input  logic [pcd_pkg::CNT_W-1:0]  divisor_i,
  output pcd_pkg::div_stat_t         stat_o
);
  import pcd_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [PROD_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [CNT_W:0]    sh;
  logic [CNT_W+1:0]  trial;
  logic              ge;

  always_comb begin
    sh    = {rem_q, quo_q[PROD_W-1]};
    trial = {1'b0, sh} - {2'b00, den_q};
    ge    = ~trial[CNT_W+1];
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(PROD_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? trial[CNT_W-1:0] : sh[CNT_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.quot = (|quo_q[PROD_W-1:PPM_W]) ? PPM_MAX : quo_q[PPM_W-1:0];

endmodule

FILE: design/pwm_co2_ppm_decoder_top.sv
// ---------------------------------------------------------------------------
// pwm_co2_ppm_decoder_top: PWM duty cycle to CO2 ppm decoder
// Times high phase and period of the sampled pin and turns the duty into
// a ppm reading through a single multiply step and a serial divider.
// ---------------------------------------------------------------------------
// Steps: a tick that closes no period is handled in ST_IDLE. A closing tick
// runs ST_CHECK and goes to ST_EMIT on an invalid period, else to ST_PREP;
// a trivial ratio goes to ST_EMIT, a division via ST_MUL, ST_DSTART, ST_DIV.
// Throughput: one transaction at a time; in_ready_o is high only when idle.
// Reset: asynchronous, active low; clears counters, flags and held ppm and
// loads the configuration defaults. No clearing pass.
module pwm_co2_ppm_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcd_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [pcd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          pin_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pcd_pkg::PPM_W-1:0]     ppm_o,
  output logic                          period_ok_o,
  output logic [pcd_pkg::PERIOD_W-1:0]  period_us_o,
  output logic                          have_reading_o
);
  import pcd_pkg::*;

  state_e state_q, state_d;

  logic [FS_W-1:0]   fs_q;
  logic [OFS_W-1:0]  hofs_q;
  logic [OFS_W-1:0]  pofs_q;
  logic [PWIN_W-1:0] pmin_q;
  logic [PWIN_W-1:0] pmax_q;

  logic              prev_q, prev_d;
  logic              seen_q, seen_d;
  logic              hdone_q, hdone_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  hw_q, hw_d;
  logic [PPM_W-1:0]  held_q, held_d;
  logic [CNT_W-1:0]  per_q, per_d;
  logic              ok_q, ok_d;
  logic [CNT_W-1:0]  num_q, num_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  logic                out_valid_q, out_valid_d;
  logic [PPM_W-1:0]    out_ppm_q, out_ppm_d;
  logic                out_ok_q, out_ok_d;
  logic [PERIOD_W-1:0] out_per_q, out_per_d;
  logic                out_have_q, out_have_d;

  logic [CNT_W-1:0] cnt_inc;
  logic [CMP_W-1:0] per_ext;
  logic [CNT_W:0]   num_sub;
  logic [CNT_W:0]   den_sub;
  logic             div_start;
  div_stat_t        div_stat;

  pcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= RST_FULL_SCALE;
      hofs_q <= RST_HIGH_OFS;
      pofs_q <= RST_PERIOD_OFS;
      pmin_q <= RST_PERIOD_MIN;
      pmax_q <= RST_PERIOD_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FULL_SCALE: fs_q   <= cfg_wdata_i[FS_W-1:0];
        REG_HIGH_OFS:   hofs_q <= cfg_wdata_i[OFS_W-1:0];
        REG_PERIOD_OFS: pofs_q <= cfg_wdata_i[OFS_W-1:0];
        REG_PERIOD_MIN: pmin_q <= cfg_wdata_i[PWIN_W-1:0];
        REG_PERIOD_MAX: pmax_q <= cfg_wdata_i[PWIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cnt_inc = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
    per_ext = CMP_W'(per_q);
    num_sub = {1'b0, hw_q} - {1'b0, CNT_W'(hofs_q)};
    den_sub = {1'b0, per_q} - {1'b0, CNT_W'(pofs_q)};

    state_d  = state_q;
    prev_d   = prev_q;
    seen_d   = seen_q;
    hdone_d  = hdone_q;
    cnt_d    = cnt_q;
    hw_d     = hw_q;
    held_d   = held_q;
    per_d    = per_q;
    ok_d     = ok_q;
    num_d    = num_q;
    den_d    = den_q;
    prod_d   = prod_q;
    div_start = 1'b0;

    out_valid_d = out_valid_q;
    out_ppm_d   = out_ppm_q;
    out_ok_d    = out_ok_q;
    out_per_d   = out_per_q;
    out_have_d  = out_have_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          prev_d = pin_level_i;
          cnt_d  = cnt_inc;
          if (pin_level_i && !prev_q) begin
            seen_d = 1'b1;
            cnt_d  = '0;
            if (hdone_q) begin
              hdone_d = 1'b0;
              per_d   = cnt_inc;
              state_d = ST_CHECK;
            end
          end else if (!pin_level_i && prev_q && seen_q) begin
            hw_d    = cnt_inc;
            hdone_d = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        ok_d    = (per_ext > CMP_W'(pmin_q)) && (per_ext < CMP_W'(pmax_q));
        state_d = ((per_ext > CMP_W'(pmin_q)) && (per_ext < CMP_W'(pmax_q)))
                  ? ST_PREP : ST_EMIT;
      end
      ST_PREP: begin
        num_d = num_sub[CNT_W-1:0];
        den_d = den_sub[CNT_W-1:0];
        if (num_sub[CNT_W] || (num_sub[CNT_W-1:0] == '0)) begin
          held_d  = '0;
          state_d = ST_EMIT;
        end else if (den_sub[CNT_W] || (den_sub[CNT_W-1:0] == '0)) begin
          held_d  = PPM_MAX;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(fs_q) * PROD_W'(num_q);
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          held_d  = div_stat.quot;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ppm_d   = held_q;
          out_ok_d    = ok_q;
          out_per_d   = (per_ext > CMP_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                       : per_ext[PERIOD_W-1:0];
          out_have_d  = (held_q != '0);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= 1'b0;
      seen_q      <= 1'b0;
      hdone_q     <= 1'b0;
      cnt_q       <= '0;
      hw_q        <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      seen_q      <= seen_d;
      hdone_q     <= hdone_d;
      cnt_q       <= cnt_d;
      hw_q        <= hw_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    per_q      <= per_d;
    ok_q       <= ok_d;
    num_q      <= num_d;
    den_q      <= den_d;
    prod_q     <= prod_d;
    out_ppm_q  <= out_ppm_d;
    out_ok_q   <= out_ok_d;
    out_per_q  <= out_per_d;
    out_have_q <= out_have_d;
  end

  assign out_valid_o    = out_valid_q;
  assign ppm_o          = out_ppm_q;
  assign period_ok_o    = out_ok_q;
  assign period_us_o    = out_per_q;
  assign have_reading_o = out_have_q;

endmodule
